// File: src/ows_pkg.sv
package ows_pkg;

    // Search geometry
    localparam int ROM_BITS  = 64;
    localparam int ROM_W     = 64;
    localparam int ROM_IDX_W = $clog2(ROM_W);
    localparam int POS_W     = 7;

    // Bus command the bus side sends when a pass starts (for reference by the bus side)
    localparam logic [7:0] SEARCH_CMD = 8'hF0;

    // Stream widths
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 72;

    typedef enum logic [1:0] {
        KIND_FIRST = 2'd0,
        KIND_NEXT  = 2'd1,
        KIND_PAIR  = 2'd2,
        KIND_LOAD  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        presence;
        logic        id_bit;
        logic        complement_bit;
        logic [2:0]  byte_index;
        logic [7:0]  load_byte;
    } item_t;

    typedef struct packed {
        logic             issue_search;
        logic             write_valid;
        logic             direction_bit;
        logic             done_res;
        logic             found;
        logic             last_device;
        logic [ROM_W-1:0] rom_code;
        logic             wrong_phase;
    } result_t;

endpackage

// File: src/ows_engine.sv
module ows_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  ows_pkg::item_t   item,
    output ows_pkg::result_t res
);
    import ows_pkg::*;

    logic [ROM_W-1:0]     rom_code_reg, rom_code_next;
    logic [POS_W-1:0]     last_branch_reg, last_branch_next;
    logic                 last_device_reg, last_device_next;
    logic [POS_W-1:0]     bit_position_reg, bit_position_next;
    logic [POS_W-1:0]     last_zero_reg, last_zero_next;
    logic                 searching_reg, searching_next;

    logic [POS_W-1:0]     pos;
    logic [ROM_IDX_W-1:0] bit_idx;
    logic                 dir;
    logic                 ldev_start;

    always_comb
    begin
        rom_code_next     = rom_code_reg;
        last_branch_next  = last_branch_reg;
        last_device_next  = last_device_reg;
        bit_position_next = bit_position_reg;
        last_zero_next    = last_zero_reg;
        searching_next    = searching_reg;
        res               = '0;
        pos               = bit_position_reg;
        bit_idx           = pos[ROM_IDX_W-1:0] - ROM_IDX_W'(1);
        dir               = 1'b0;
        ldev_start        = (item.kind == KIND_FIRST) ? 1'b0 : last_device_reg;

        case (item.kind)
            KIND_FIRST, KIND_NEXT:
            begin
                if (item.kind == KIND_FIRST)
                begin
                    last_branch_next = '0;
                    last_device_next = 1'b0;
                end
                bit_position_next = POS_W'(1);
                last_zero_next    = '0;
                searching_next    = 1'b0;
                if (ldev_start || !item.presence)
                begin
                    last_branch_next = '0;
                    last_device_next = 1'b0;
                    res.done_res     = 1'b1;
                end
                else
                begin
                    searching_next   = 1'b1;
                    res.issue_search = 1'b1;
                end
            end
            KIND_PAIR:
            begin
                if (!searching_reg)
                begin
                    res.wrong_phase = 1'b1;
                end
                else if (item.id_bit && item.complement_bit)
                begin
                    // no device answered this bit: abort the pass
                    searching_next   = 1'b0;
                    last_branch_next = '0;
                    last_device_next = 1'b0;
                    res.done_res     = 1'b1;
                end
                else
                begin
                    if (item.id_bit != item.complement_bit)
                    begin
                        dir = item.id_bit;
                    end
                    else
                    begin
                        // fork: repeat the old path below the last branch, take 1 at it
                        if (pos < last_branch_reg)
                            dir = rom_code_reg[bit_idx];
                        else
                            dir = (pos == last_branch_reg);
                        if (!dir)
                            last_zero_next = pos;
                    end
                    rom_code_next[bit_idx] = dir;
                    res.write_valid        = 1'b1;
                    res.direction_bit      = dir;
                    bit_position_next      = pos + POS_W'(1);
                    if (pos >= POS_W'(ROM_BITS))
                    begin
                        searching_next   = 1'b0;
                        res.done_res     = 1'b1;
                        last_branch_next = last_zero_next;
                        last_device_next = (last_zero_next == '0);
                        res.found        = 1'b1;
                        if (rom_code_next[7:0] == 8'd0)
                        begin
                            last_branch_next = '0;
                            last_device_next = 1'b0;
                            res.found        = 1'b0;
                        end
                    end
                end
            end
            KIND_LOAD:
            begin
                if (searching_reg)
                    res.wrong_phase = 1'b1;
                else
                    rom_code_next[{item.byte_index, 3'b000} +: 8] = item.load_byte;
            end
            default:
            begin
            end
        endcase

        res.rom_code    = rom_code_next;
        res.last_device = res.done_res ? last_device_next : 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_code_reg     <= '0;
            last_branch_reg  <= '0;
            last_device_reg  <= 1'b0;
            bit_position_reg <= POS_W'(1);
            last_zero_reg    <= '0;
            searching_reg    <= 1'b0;
        end
        else if (step)
        begin
            rom_code_reg     <= rom_code_next;
            last_branch_reg  <= last_branch_next;
            last_device_reg  <= last_device_next;
            bit_position_reg <= bit_position_next;
            last_zero_reg    <= last_zero_next;
            searching_reg    <= searching_next;
        end
    end

    // a pass in progress always points at a bit inside the code
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        searching_reg |-> (bit_position_reg != '0 && bit_position_reg <= POS_W'(ROM_BITS)))
        else $error("bit position out of range during a pass");

    a_write_needs_pass: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.write_valid |-> searching_reg)
        else $error("direction bit written outside a pass");

    a_done_ends_pass: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.done_res |=> !searching_reg)
        else $error("pass still running after done");

    a_found_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.found |-> res.done_res && !res.issue_search)
        else $error("found reported without done");

    a_issue_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.issue_search |=> searching_reg && bit_position_reg == POS_W'(1))
        else $error("search command without a fresh pass");

endmodule

// File: src/onewire_rom_search.sv
// 1-Wire ROM search decision engine.
// Throughput: 1 item per cycle while m_tready allows; an accepted item passes one input
// register, the decision logic and one result register before its result shows on m_tvalid.
// A stalled output holds the result register and the input register backs up behind it.
// Reset (rst_n low, asynchronous): empty both registers, zero the ROM code and search
// state, bit position back to one.
module onewire_rom_search (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // presence[0], id_bit[1], complement_bit[2], byte_index[5:3], load_byte[13:6], zero pad
    input  logic [ows_pkg::S_DATA_W-1:0]   s_tdata,
    // kind[1:0]
    input  logic [ows_pkg::S_USER_W-1:0]   s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // issue_search[0], write_valid[1], direction_bit[2], done_res[3], found[4],
    // last_device[5], rom_code[69:6], wrong_phase[70], zero pad
    output logic [ows_pkg::M_DATA_W-1:0]   m_tdata
);
    import ows_pkg::*;

    item_t   item_reg;
    logic    in_valid_reg, in_valid_next;
    result_t res_reg;
    result_t res;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    item_t   in_item;

    // unpack the incoming item
    assign in_item.kind           = kind_t'(s_tuser);
    assign in_item.presence       = s_tdata[0];
    assign in_item.id_bit         = s_tdata[1];
    assign in_item.complement_bit = s_tdata[2];
    assign in_item.byte_index     = s_tdata[5:3];
    assign in_item.load_byte      = s_tdata[13:6];

    // move the held item into the result register whenever that register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    ows_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: load on handshake, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= in_item;
        if (advance)
            res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_reg.wrong_phase, res_reg.rom_code, res_reg.last_device,
                       res_reg.found, res_reg.done_res, res_reg.direction_bit,
                       res_reg.write_valid, res_reg.issue_search};

endmodule

// File: tb/onewire_rom_search_test.sv
`timescale 1ns / 1ps

module onewire_rom_search_test;

    import ows_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 1220;
    localparam int RX_HOLD_CYCLES = 60;
    localparam int TAIL_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTS     = 20;

    // Flag groups for typed results, ordered {issue, write_valid, dir, done, found, last}
    localparam logic [5:0] F_NONE  = 6'b000000;
    localparam logic [5:0] F_ISSUE = 6'b100000;
    localparam logic [5:0] F_DONE  = 6'b000100;

    localparam result_t UNCHECKED = '0;

    // One line of the directed plan: an item, how often to send it, and an
    // optional result typed in by hand
    typedef struct packed {
        item_t      it;
        logic [7:0] reps;
        logic       fixed;
        result_t    res;
    } plan_row_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic [S_USER_W-1:0]  s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;

    // Search state as the block should hold it
    logic [ROM_W-1:0]     rom_image;
    logic [POS_W-1:0]     branch_mark;
    logic                 final_device;
    logic [POS_W-1:0]     next_bit;
    logic [POS_W-1:0]     zero_fork;
    logic                 pass_open;

    result_t              pending_results [$];
    logic                 fixed_flag_q [$];
    result_t              fixed_result_q [$];
    plan_row_t            plan [$];

    int                   mismatches  = 0;
    int                   quiet_cycles = 0;
    logic                 no_idle = 1'b0;
    logic                 rx_hold = 1'b0;

    onewire_rom_search u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Work out the result of one item and advance the search state
    function automatic result_t decide_search_step(input item_t it);
        result_t    r;
        logic [6:0] pos;
        logic [5:0] bit_idx;
        logic       dir;
        r = '0;
        case (it.kind)
            KIND_FIRST, KIND_NEXT:
            begin
                if (it.kind == KIND_FIRST)
                begin
                    branch_mark  = '0;
                    final_device = 1'b0;
                end
                next_bit  = 7'd1;
                zero_fork = '0;
                pass_open = 1'b0;
                // nothing left to find, or nobody on the bus: restart from scratch
                if (final_device || !it.presence)
                begin
                    branch_mark    = '0;
                    final_device   = 1'b0;
                    r.done_res     = 1'b1;
                end
                else
                begin
                    pass_open      = 1'b1;
                    r.issue_search = 1'b1;
                end
            end
            KIND_PAIR:
            begin
                if (!pass_open)
                    r.wrong_phase = 1'b1;
                else if (it.id_bit && it.complement_bit)
                begin
                    // no device answered this bit: abort the pass
                    pass_open    = 1'b0;
                    branch_mark  = '0;
                    final_device = 1'b0;
                    r.done_res   = 1'b1;
                end
                else
                begin
                    pos     = next_bit;
                    bit_idx = 6'(pos - 7'd1);
                    if (it.id_bit != it.complement_bit)
                        dir = it.id_bit;
                    else
                    begin
                        // fork: replay the previous path below the last branch,
                        // take 1 at it, and 0 beyond it
                        if (pos < branch_mark)
                            dir = rom_image[bit_idx];
                        else
                            dir = (pos == branch_mark);
                        if (!dir)
                            zero_fork = pos;
                    end
                    rom_image[bit_idx] = dir;
                    r.write_valid      = 1'b1;
                    r.direction_bit    = dir;
                    next_bit           = pos + 7'd1;
                    if (pos >= ROM_BITS)
                    begin
                        pass_open    = 1'b0;
                        r.done_res   = 1'b1;
                        branch_mark  = zero_fork;
                        final_device = (branch_mark == '0);
                        r.found      = 1'b1;
                        // a zero family byte is no valid device
                        if (rom_image[7:0] == 8'h00)
                        begin
                            branch_mark  = '0;
                            final_device = 1'b0;
                            r.found      = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                if (pass_open)
                    r.wrong_phase = 1'b1;
                else
                    rom_image[it.byte_index * 8 +: 8] = it.load_byte;
            end
        endcase
        r.last_device = r.done_res ? final_device : 1'b0;
        r.rom_code    = rom_image;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < MAX_PRINTS)
            $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    // Score results against the oldest expectation, then record expectations
    // for items accepted at this edge
    always @(posedge clk)
    begin : score
        result_t seen;
        result_t want;
        result_t guess;
        item_t   taken;
        logic    fixed;
        if (!rst_n)
        begin
            // predictor state as after reset
            rom_image    = '0;
            branch_mark  = '0;
            final_device = 1'b0;
            next_bit     = 7'd1;
            zero_fork    = '0;
            pass_open    = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen = {m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[3], m_tdata[4],
                        m_tdata[5], m_tdata[69:6], m_tdata[70]};
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing expected", seen.rom_code, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (seen.issue_search !== want.issue_search)
                        report_mismatch("issue_search", 64'(seen.issue_search),
                                        64'(want.issue_search));
                    if (seen.write_valid !== want.write_valid)
                        report_mismatch("write_valid", 64'(seen.write_valid),
                                        64'(want.write_valid));
                    if (seen.direction_bit !== want.direction_bit)
                        report_mismatch("direction_bit", 64'(seen.direction_bit),
                                        64'(want.direction_bit));
                    if (seen.done_res !== want.done_res)
                        report_mismatch("done_res", 64'(seen.done_res), 64'(want.done_res));
                    if (seen.found !== want.found)
                        report_mismatch("found", 64'(seen.found), 64'(want.found));
                    if (seen.last_device !== want.last_device)
                        report_mismatch("last_device", 64'(seen.last_device),
                                        64'(want.last_device));
                    if (seen.rom_code !== want.rom_code)
                        report_mismatch("rom_code", seen.rom_code, want.rom_code);
                    if (seen.wrong_phase !== want.wrong_phase)
                        report_mismatch("wrong_phase", 64'(seen.wrong_phase),
                                        64'(want.wrong_phase));
                end
            end
            if (s_tvalid && s_tready)
            begin
                taken = {s_tuser, s_tdata[0], s_tdata[1], s_tdata[2], s_tdata[5:3],
                         s_tdata[13:6]};
                // always advance the predictor, even when the row has a typed result
                guess = decide_search_step(taken);
                fixed = fixed_flag_q.pop_front();
                want  = fixed_result_q.pop_front();
                pending_results.push_back(fixed ? want : guess);
            end
        end
    end

    // End the run when nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Mostly no gap, sometimes a short or medium one, rarely a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic item_t random_item();
        logic [15:0] raw;
        raw = 16'($urandom);
        return raw;
    endfunction

    function automatic plan_row_t row(input item_t it, input int reps, input logic fixed,
                                      input result_t res);
        plan_row_t r;
        r.it    = it;
        r.reps  = 8'(reps);
        r.fixed = fixed;
        r.res   = res;
        return r;
    endfunction

    // Offer one item, hold it until taken, then idle for a random gap
    task automatic send_item(input item_t it, input logic fixed, input result_t res);
        int gap;
        fixed_flag_q.push_back(fixed);
        fixed_result_q.push_back(res);
        s_tdata  <= {2'b00, it.load_byte, it.byte_index, it.complement_bit, it.id_bit,
                     it.presence};
        s_tuser  <= it.kind;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Receiver: random stalls, a ready stretch in burst mode, and one long hold
    initial
    begin
        int stall;
        stall = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold)
            begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
                m_tready <= 1'b1;
            end
            else if (no_idle)
                m_tready <= 1'b1;
            else
            begin
                if (stall == 0)
                    stall = pick_gap();
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    stall--;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    // Sender: directed plan, then random search passes
    initial
    begin
        int    counted;
        int    pass_no;
        int    npairs;
        int    style;
        int    abort_at;
        int    k;
        logic  answered;
        item_t it;

        counted = 0;
        pass_no = 0;

        // pair and load in the wrong phase, loads at both byte ends, missing presence
        plan.push_back(row({KIND_PAIR, 1'b0, 1'b1, 1'b0, 3'd0, 8'h00}, 1, 1'b1,
                           {F_NONE, 64'h0, 1'b1}));
        plan.push_back(row({KIND_LOAD, 1'b0, 1'b0, 1'b0, 3'd7, 8'hFF}, 1, 1'b1,
                           {F_NONE, 64'hFF00_0000_0000_0000, 1'b0}));
        plan.push_back(row({KIND_LOAD, 1'b1, 1'b1, 1'b1, 3'd0, 8'h00}, 1, 1'b1,
                           {F_NONE, 64'hFF00_0000_0000_0000, 1'b0}));
        plan.push_back(row({KIND_FIRST, 1'b0, 1'b0, 1'b0, 3'd0, 8'h00}, 1, 1'b1,
                           {F_DONE, 64'hFF00_0000_0000_0000, 1'b0}));
        plan.push_back(row({KIND_LOAD, 1'b0, 1'b0, 1'b0, 3'd7, 8'h00}, 1, 1'b1,
                           {F_NONE, 64'h0, 1'b0}));
        plan.push_back(row({KIND_FIRST, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00}, 1, 1'b1,
                           {F_ISSUE, 64'h0, 1'b0}));
        plan.push_back(row({KIND_LOAD, 1'b0, 1'b0, 1'b0, 3'd2, 8'h55}, 1, 1'b1,
                           {F_NONE, 64'h0, 1'b1}));
        // forks everywhere, all zeros: the family byte is zero
        plan.push_back(row({KIND_PAIR, 1'b0, 1'b0, 1'b0, 3'd0, 8'h00}, 64, 1'b0, UNCHECKED));
        // full pass with family 0xFF and forks taken at 0
        plan.push_back(row({KIND_FIRST, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00}, 1, 1'b1,
                           {F_ISSUE, 64'h0, 1'b0}));
        plan.push_back(row({KIND_PAIR, 1'b0, 1'b1, 1'b0, 3'd0, 8'h00}, 8, 1'b0, UNCHECKED));
        plan.push_back(row({KIND_PAIR, 1'b0, 1'b0, 1'b0, 3'd0, 8'h00}, 56, 1'b0, UNCHECKED));
        plan.push_back(row({KIND_NEXT, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00}, 1, 1'b1,
                           {F_ISSUE, 64'hFF, 1'b0}));
        plan.push_back(row({KIND_PAIR, 1'b0, 1'b0, 1'b1, 3'd0, 8'h00}, 1, 1'b0, UNCHECKED));
        // begin in the middle of a pass, then both bits read 1
        plan.push_back(row({KIND_FIRST, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00}, 1, 1'b1,
                           {F_ISSUE, 64'hFE, 1'b0}));
        plan.push_back(row({KIND_PAIR, 1'b0, 1'b1, 1'b1, 3'd0, 8'h00}, 1, 1'b1,
                           {F_DONE, 64'hFE, 1'b0}));
        plan.push_back(row({KIND_PAIR, 1'b0, 1'b0, 1'b1, 3'd0, 8'h00}, 1, 1'b1,
                           {F_NONE, 64'hFE, 1'b1}));
        // single device: no forks, so it is the last one
        plan.push_back(row({KIND_FIRST, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00}, 1, 1'b1,
                           {F_ISSUE, 64'hFE, 1'b0}));
        plan.push_back(row({KIND_PAIR, 1'b0, 1'b1, 1'b0, 3'd0, 8'h00}, 64, 1'b0, UNCHECKED));
        plan.push_back(row({KIND_NEXT, 1'b1, 1'b0, 1'b0, 3'd0, 8'h00}, 1, 1'b1,
                           {F_DONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0}));
        plan.push_back(row({KIND_NEXT, 1'b0, 1'b0, 1'b0, 3'd0, 8'h00}, 1, 1'b1,
                           {F_DONE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0}));
        plan.push_back(row({KIND_LOAD, 1'b0, 1'b0, 1'b0, 3'd5, 8'h5A}, 1, 1'b1,
                           {F_NONE, 64'hFFFF_5AFF_FFFF_FFFF, 1'b0}));
        plan.push_back(row({KIND_LOAD, 1'b0, 1'b0, 1'b0, 3'd3, 8'h00}, 1, 1'b1,
                           {F_NONE, 64'hFFFF_5AFF_00FF_FFFF, 1'b0}));

        wait (rst_n);
        @(posedge clk);

        foreach (plan[i])
            for (k = 0; k < plan[i].reps; k++)
                send_item(plan[i].it, plan[i].fixed, plan[i].res);
        drain_results();

        while (counted < RANDOM_ITEMS)
        begin
            pass_no++;
            // every few passes hold the sender until all results are back
            if (pass_no % 6 == 0)
                drain_results();
            no_idle = (pass_no % 5 == 2);
            // stall the receiver long while items keep coming back to back
            if (pass_no == 4)
            begin
                rx_hold = 1'b1;
                no_idle = 1'b1;
            end

            // preset ROM bytes between passes
            if ($urandom_range(0, 99) < 30)
                repeat ($urandom_range(1, 3))
                begin
                    it      = random_item();
                    it.kind = KIND_LOAD;
                    send_item(it, 1'b0, UNCHECKED);
                    counted++;
                end
            // noise: anything at all
            if ($urandom_range(0, 99) < 15)
                repeat ($urandom_range(1, 3))
                    send_item(random_item(), 1'b0, UNCHECKED);

            it          = random_item();
            it.kind     = ($urandom_range(0, 99) < 35) ? KIND_FIRST : KIND_NEXT;
            it.presence = ($urandom_range(0, 9) != 0);
            answered    = it.presence;
            send_item(it, 1'b0, UNCHECKED);
            counted++;

            // no presence: up to two stray pairs, which the block flags as wrong phase
            if (!answered)
                npairs = $urandom_range(0, 2);
            else if ($urandom_range(0, 9) == 0)
                npairs = $urandom_range(1, ROM_BITS - 1);
            else
                npairs = ROM_BITS;
            style    = $urandom_range(0, 9);
            abort_at = ($urandom_range(0, 19) == 0) ? $urandom_range(1, ROM_BITS) : 0;

            for (k = 1; k <= npairs; k++)
            begin
                it                = random_item();
                it.kind           = KIND_PAIR;
                it.id_bit         = 1'($urandom_range(0, 1));
                it.complement_bit = !it.id_bit;
                if (k == abort_at || $urandom_range(0, 299) == 0)
                begin
                    it.id_bit         = 1'b1;
                    it.complement_bit = 1'b1;
                end
                else if (style == 3 && k <= 8)
                begin
                    // drive the family byte to zero
                    it.id_bit         = 1'b0;
                    it.complement_bit = 1'b1;
                end
                else if (style > 3 && $urandom_range(0, 99) < 12)
                begin
                    it.id_bit         = 1'b0;
                    it.complement_bit = 1'b0;
                end
                send_item(it, 1'b0, UNCHECKED);
                if (answered)
                    counted++;
            end
        end

        no_idle = 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
